/* rtl/kpd_pkg.sv */
// Package for the keypad scan press detector.
// Holds key map types, sizes, configuration register indexes and reset values.
// No dependencies.
package kpd_pkg;

    localparam int KEYS          = 16;
    localparam int MAX_ROWS      = 16;
    localparam int HISTORY_DEPTH = 4;
    localparam int HISTORY_HALF  = HISTORY_DEPTH / 2;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int IDX_W         = 10;

    typedef logic [KEYS-1:0]  t_key_map;
    typedef logic [15:0]      t_levels;
    typedef logic [3:0]       t_column;
    typedef logic [31:0]      t_time;
    typedef logic [CFG_W-1:0] t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_ROW_COUNT = 1'd0;
    localparam t_cfg_idx REG_COL_COUNT = 1'd1;

    localparam t_cfg ROW_COUNT_RESET = 5'd4;
    localparam t_cfg COL_COUNT_RESET = 5'd4;
    localparam t_cfg ROWS_LIMIT      = 5'(MAX_ROWS);

    localparam t_key_map ALL_ONES = '1;

endpackage

/* rtl/kpd_in_if.sv */
// Input channel of the keypad scan press detector: one column sample per transaction.
// Depends on kpd_pkg.
interface kpd_in_if;
    import kpd_pkg::*;

    logic    valid;
    logic    ready;
    t_column column;
    t_levels row_levels;
    logic    last_column;
    t_time   now;

    modport source (output valid, column, row_levels, last_column, now, input ready);
    modport sink   (input valid, column, row_levels, last_column, now, output ready);
endinterface

/* rtl/kpd_out_if.sv */
// Output channel of the keypad scan press detector: one result per completed scan.
// Depends on kpd_pkg.
interface kpd_out_if;
    import kpd_pkg::*;

    logic     valid;
    logic     ready;
    t_key_map down_keys;
    t_key_map press_keys;

    modport source (output valid, down_keys, press_keys, input ready);
    modport sink   (input valid, down_keys, press_keys, output ready);
endinterface

/* rtl/kpd_scatter.sv */
// Scatters the row levels of one column sample into the key down map.
// Depends on kpd_pkg.
module kpd_scatter (
    input  kpd_pkg::t_cfg     i_row_count,
    input  kpd_pkg::t_cfg     i_col_count,
    input  kpd_pkg::t_column  i_column,
    input  kpd_pkg::t_levels  i_row_levels,
    input  kpd_pkg::t_key_map i_down,
    output kpd_pkg::t_key_map o_down
);
    import kpd_pkg::*;

    t_cfg             rows_eff;
    logic [IDX_W-1:0] idx [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_on;

    assign rows_eff = (i_row_count > ROWS_LIMIT) ? ROWS_LIMIT : i_row_count;

    always_comb begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            idx[r]    = IDX_W'(r) * IDX_W'(i_col_count) + IDX_W'(i_column);
            row_on[r] = CFG_W'(r) < rows_eff;
        end
    end

    // Where several rows land on one key, the highest row wins.
    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            o_down[k] = i_down[k];
            for (int r = 0; r < MAX_ROWS; r++) begin
                if (row_on[r] && idx[r] == IDX_W'(k)) begin
                    o_down[k] = ~i_row_levels[r];
                end
            end
        end
    end
endmodule

/* rtl/keypad_scan_press_detector.sv */
// Keypad scan press detector top level.
// Depends on kpd_pkg, kpd_in_if, kpd_out_if and kpd_scatter.
//
// Usage:
// The input channel carries one column sample per transaction: the column index,
// the active-low row levels, a last-column flag and a millisecond time stamp.
// Each sample updates the key down map. A sample with the last-column flag ends
// a scan and produces one transaction on the output channel with the down map
// and the map of debounced new presses; other samples produce nothing.
// The configuration port writes the row count and the column count.
// Throughput is one sample per cycle while no last-column sample has to wait.
// An accepted sample enters the input register; its result, the output register.
// The window history, down map and window time update in the same single cycle.
// When the receiver stalls, the result waits in the output register; samples
// without the flag keep flowing, and a last-column sample waits in the input
// register until the output register is free.
// Reset clears the down map, the window history and the window time, and sets
// both counts to four. There is no clearing pass.
module keypad_scan_press_detector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kpd_in_if.sink             i_in,
    kpd_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  kpd_pkg::t_cfg_idx  i_cfg_index,
    input  kpd_pkg::t_cfg      i_cfg_wdata
);
    import kpd_pkg::*;

    t_cfg     r_row_count;
    t_cfg     r_col_count;
    logic     r_stg_valid;
    t_column  r_stg_column;
    t_levels  r_stg_levels;
    logic     r_stg_last;
    t_time    r_stg_now;
    t_key_map r_down;
    t_key_map r_hist [HISTORY_DEPTH];
    t_time    r_wtime;
    logic     r_out_valid;
    t_key_map r_out_down;
    t_key_map r_out_press;

    t_key_map n_down;
    t_key_map held;
    t_key_map was_up;
    logic     win_open;
    logic     stg_go;
    logic     stg_adv;
    logic     in_ready;

    kpd_scatter u_scatter (
        .i_row_count  (r_row_count),
        .i_col_count  (r_col_count),
        .i_column     (r_stg_column),
        .i_row_levels (r_stg_levels),
        .i_down       (r_down),
        .o_down       (n_down)
    );

    always_comb begin
        held   = ALL_ONES;
        was_up = ALL_ONES;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (i < HISTORY_HALF) begin
                held = held & r_hist[i];
            end else begin
                was_up = was_up & ~r_hist[i];
            end
        end
    end

    assign win_open = r_stg_now > r_wtime;
    assign stg_go   = !r_stg_last || !r_out_valid || o_out.ready;
    assign stg_adv  = r_stg_valid && stg_go;
    assign in_ready = !r_stg_valid || stg_go;

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.down_keys  = r_out_down;
    assign o_out.press_keys = r_out_press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RESET;
            r_col_count <= COL_COUNT_RESET;
            r_stg_valid <= 1'b0;
            r_down      <= '0;
            r_wtime     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ROW_COUNT: r_row_count <= i_cfg_wdata;
                    REG_COL_COUNT: r_col_count <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (in_ready) begin
                r_stg_valid <= i_in.valid;
                if (i_in.valid) begin
                    r_stg_column <= i_in.column;
                    r_stg_levels <= i_in.row_levels;
                    r_stg_last   <= i_in.last_column;
                    r_stg_now    <= i_in.now;
                end
            end

            if (stg_adv) begin
                r_down <= n_down;
                if (r_stg_last) begin
                    if (win_open) begin
                        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                            r_hist[i] <= r_hist[i-1];
                        end
                        r_hist[0] <= n_down;
                        r_wtime   <= r_stg_now;
                    end else begin
                        r_hist[0] <= r_hist[0] & n_down;
                    end
                end
            end

            if (stg_adv && r_stg_last) begin
                r_out_valid <= 1'b1;
                r_out_down  <= n_down;
                r_out_press <= win_open ? (held & was_up) : '0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

/* rtl/kpd_checker.sv */
// Port-level checks for the keypad scan press detector, bound to the top level.
// Depends on kpd_pkg and keypad_scan_press_detector.
module kpd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_last,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input kpd_pkg::t_key_map i_out_down,
    input kpd_pkg::t_key_map i_out_press
);
    import kpd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_down) && $stable(i_out_press))
        else $error("stalled result changed or was dropped");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result without a last-column transaction two cycles earlier");

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while the output register is empty");
endmodule

bind keypad_scan_press_detector kpd_checker u_kpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_column),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_down  (o_out.down_keys),
    .i_out_press (o_out.press_keys)
);

/* test/tb_keypad_scan_press_detector.sv */
`timescale 1ns / 1ps
// Self-checking testbench for keypad_scan_press_detector: directed scans, then random phases.
// Depends on kpd_pkg, kpd_in_if, kpd_out_if and the RTL of the block.
module tb_keypad_scan_press_detector;
    import kpd_pkg::*;

    localparam int DIRECTED_LEN   = 27;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 120;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 400;

    typedef enum logic {STEP_SAMPLE, STEP_CONFIG} t_step_kind;
    typedef enum logic [1:0] {IDLE_RANDOM, IDLE_NONE, IDLE_HOLD} t_idle_mode;

    typedef struct {
        t_column column;
        t_levels row_levels;
        logic    last_column;
        t_time   now;
    } t_sample;

    typedef struct {
        t_key_map down_keys;
        t_key_map press_keys;
    } t_result;

    typedef struct {
        t_step_kind kind;
        t_cfg_idx   cfg_idx;
        t_cfg       cfg_value;
        t_column    column;
        t_levels    row_levels;
        logic       last_column;
        t_time      now;
        bit         known;
        t_key_map   down_keys;
        t_key_map   press_keys;
    } t_step;

    typedef struct {
        t_cfg       rows;
        t_cfg       cols;
        int         scan_cols;
        t_idle_mode mode;
        bit         wrap_time;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_index;
    t_cfg i_cfg_wdata;

    kpd_in_if  in_ch();
    kpd_out_if out_ch();

    keypad_scan_press_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state, at its reset values.
    t_cfg     rows_cfg = ROW_COUNT_RESET;
    t_cfg     cols_cfg = COL_COUNT_RESET;
    t_key_map down_map = '0;
    t_key_map window_hist [HISTORY_DEPTH] = '{default: '0};
    t_time    window_start = '0;

    t_result    pending_results [$];
    int         error_count = 0;
    int         items_sent = 0;
    int         idle_cycles = 0;
    t_idle_mode mode = IDLE_RANDOM;
    bit         long_hold_req = 1'b0;
    bit         want_known;
    t_result    want_result;
    t_time      clock_ms = 32'd10;
    t_levels    col_pattern [16] = '{default: '1};

    t_step directed_steps [DIRECTED_LEN] = '{
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd0, 16'hFFFF, 1'b1, 32'd0, 1'b1, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd0, 16'h0000, 1'b0, 32'd1, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd1, 16'h0000, 1'b0, 32'd1, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd2, 16'h0000, 1'b0, 32'd1, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd3, 16'h0000, 1'b1, 32'd1, 1'b1, 16'hFFFF, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd3, 16'h0000, 1'b1, 32'd2, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd3, 16'h0000, 1'b1, 32'd3, 1'b1, 16'hFFFF, 16'hFFFF},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd3, 16'h0000, 1'b1, 32'd3, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd0, 16'hFFFF, 1'b0, 32'd4, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd1, 16'hFFFF, 1'b0, 32'd4, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd2, 16'hFFFF, 1'b0, 32'd4, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd3, 16'hFFFF, 1'b1, 32'd4, 1'b0, 16'h0000, 16'h0000},
        '{STEP_CONFIG, REG_ROW_COUNT, 5'd16, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000},
        '{STEP_CONFIG, REG_COL_COUNT, 5'd1, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd0, 16'h5A5A, 1'b1, 32'd5, 1'b1, 16'hA5A5, 16'h0000},
        '{STEP_CONFIG, REG_ROW_COUNT, 5'd31, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd0, 16'h0000, 1'b1, 32'd5, 1'b0, 16'h0000, 16'h0000},
        '{STEP_CONFIG, REG_COL_COUNT, 5'd0, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd7, 16'h7FFF, 1'b1, 32'd6, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd9, 16'h8000, 1'b1, 32'd6, 1'b0, 16'h0000, 16'h0000},
        '{STEP_CONFIG, REG_COL_COUNT, 5'd31, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000},
        '{STEP_CONFIG, REG_ROW_COUNT, 5'd1, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd15, 16'h0000, 1'b1, 32'd7, 1'b0, 16'h0000, 16'h0000},
        '{STEP_CONFIG, REG_ROW_COUNT, 5'd16, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000},
        '{STEP_SAMPLE, REG_ROW_COUNT, 5'd0, 4'd15, 16'h0000, 1'b1, 32'd8, 1'b0, 16'h0000, 16'h0000},
        '{STEP_CONFIG, REG_ROW_COUNT, 5'd4, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000},
        '{STEP_CONFIG, REG_COL_COUNT, 5'd4, 4'd0, 16'h0000, 1'b0, 32'd0, 1'b0, 16'h0000, 16'h0000}
    };

    t_phase random_phases [PHASE_COUNT] = '{
        '{5'd4,  5'd4,  4,  IDLE_RANDOM, 1'b0},
        '{5'd16, 5'd1,  1,  IDLE_HOLD,   1'b0},
        '{5'd1,  5'd16, 16, IDLE_RANDOM, 1'b0},
        '{5'd2,  5'd8,  8,  IDLE_NONE,   1'b0},
        '{5'd8,  5'd2,  2,  IDLE_RANDOM, 1'b0},
        '{5'd3,  5'd5,  5,  IDLE_RANDOM, 1'b0},
        '{5'd16, 5'd16, 16, IDLE_RANDOM, 1'b0},
        '{5'd31, 5'd0,  4,  IDLE_RANDOM, 1'b0},
        '{5'd5,  5'd31, 16, IDLE_NONE,   1'b0},
        '{5'd4,  5'd4,  4,  IDLE_RANDOM, 1'b1}
    };

    // Applies one column sample to the predicted key state; returns 1 when a scan completes.
    function automatic bit scan_column(input t_sample s, output t_result res);
        int rows;
        int key;
        t_key_map held;
        t_key_map was_up;
        rows = (rows_cfg > ROWS_LIMIT) ? MAX_ROWS : int'(rows_cfg);
        for (int r = 0; r < rows; r++) begin
            key = r * int'(cols_cfg) + int'(s.column);
            if (key < KEYS) down_map[key] = ~s.row_levels[r];
        end
        res.down_keys = down_map;
        res.press_keys = '0;
        if (!s.last_column) return 1'b0;
        if (s.now > window_start) begin
            held = ALL_ONES;
            was_up = ALL_ONES;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                if (i < HISTORY_HALF) held &= window_hist[i];
                else was_up &= ~window_hist[i];
            end
            res.press_keys = held & was_up;
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) window_hist[i] = window_hist[i-1];
            window_hist[0] = ALL_ONES;
            window_start = s.now;
        end
        window_hist[0] &= down_map;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor_proc
        t_sample s;
        t_result res;
        t_result oldest;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROW_COUNT: rows_cfg = i_cfg_wdata;
                    REG_COL_COUNT: cols_cfg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                s = '{in_ch.column, in_ch.row_levels, in_ch.last_column, in_ch.now};
                if (scan_column(s, res)) pending_results.push_back(want_known ? want_result : res);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: down_keys %h, press_keys %h",
                           out_ch.down_keys, out_ch.press_keys);
                    error_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (out_ch.down_keys !== oldest.down_keys) begin
                        $error("down_keys: expected %h, actual %h",
                               oldest.down_keys, out_ch.down_keys);
                        error_count++;
                    end
                    if (out_ch.press_keys !== oldest.press_keys) begin
                        $error("press_keys: expected %h, actual %h",
                               oldest.press_keys, out_ch.press_keys);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("keypad_scan_press_detector regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result receiver: random stalls, plus one long hold-off when requested.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                gap = (mode == IDLE_NONE) ? 0 : $urandom_range(0, 9);
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_sample(input t_sample s, input bit known, input t_result want);
        int gap;
        gap = (mode == IDLE_RANDOM) ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.column <= s.column;
        in_ch.row_levels <= s.row_levels;
        in_ch.last_column <= s.last_column;
        in_ch.now <= s.now;
        want_known <= known;
        want_result <= want;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic program_register(input t_cfg_idx idx, input t_cfg value);
        in_ch.valid <= 1'b0;
        do begin
            while (pending_results.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end while (pending_results.size() != 0);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly complete scans over slowly changing key patterns, with some stray samples.
    task automatic run_scans(input int target, input int scan_cols);
        t_sample s;
        t_result none;
        int start;
        none = '{'0, '0};
        start = items_sent;
        while (items_sent - start < target) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    s.column = t_column'($urandom_range(0, 15));
                    s.row_levels = t_levels'($urandom);
                    s.last_column = 1'($urandom_range(0, 1));
                    s.now = (clock_ms > 2) ? clock_ms - $urandom_range(0, 2) : clock_ms;
                    send_sample(s, 1'b0, none);
                end
            end else begin
                if ($urandom_range(0, 2) == 0)
                    col_pattern[$urandom_range(0, scan_cols - 1)][$urandom_range(0, 15)] ^= 1'b1;
                clock_ms += $urandom_range(0, 2);
                for (int c = 0; c < scan_cols; c++) begin
                    s.column = t_column'(c);
                    s.row_levels = col_pattern[c];
                    s.last_column = (c == scan_cols - 1);
                    s.now = clock_ms;
                    send_sample(s, 1'b0, none);
                end
            end
        end
    endtask

    initial begin
        t_sample s;
        t_result want;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_ROW_COUNT;
        i_cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.column <= '0;
        in_ch.row_levels <= '1;
        in_ch.last_column <= 1'b0;
        in_ch.now <= '0;
        want_known <= 1'b0;
        want_result <= '{'0, '0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_CONFIG) begin
                program_register(directed_steps[i].cfg_idx, directed_steps[i].cfg_value);
            end else begin
                s = '{directed_steps[i].column, directed_steps[i].row_levels,
                      directed_steps[i].last_column, directed_steps[i].now};
                want = '{directed_steps[i].down_keys, directed_steps[i].press_keys};
                send_sample(s, directed_steps[i].known, want);
            end
        end

        foreach (random_phases[p]) begin
            program_register(REG_ROW_COUNT, random_phases[p].rows);
            program_register(REG_COL_COUNT, random_phases[p].cols);
            mode = random_phases[p].mode;
            if (mode == IDLE_HOLD) long_hold_req = 1'b1;
            if (random_phases[p].wrap_time) clock_ms = 32'hFFFF_FFF0;
            run_scans(PHASE_ITEMS, random_phases[p].scan_cols);
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("keypad_scan_press_detector regression: pass");
        else
            $display("keypad_scan_press_detector regression: fail");
        $finish;
    end

endmodule
